// ===== hw/rtl/fdrt_pkg.sv =====
`timescale 1ns / 1ps

package fdrt_pkg;

  // Default widths
  localparam int DUTY_BITS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths
  localparam int OP_W       = 2;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Item kinds
  localparam logic [OP_W-1:0] OP_DUTY = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_EDGE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_OFF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUNTIME = 2'd3;

  // Register reset values
  localparam logic [OUT_W-1:0] MIN_RUNTIME_RST = 32'd30000;

  // Two tach edges per revolution, window counted in ms ticks: rpm = edges * 60000 / (2 * window), rounded half up
  localparam int RPM_NUM = 60000;

  // Numerator growth over the edge counter width (60001 * 2^COUNT_BITS, plus headroom)
  localparam int NUM_EXTRA = 17;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

// ===== hw/rtl/fdrt_in_if.sv =====
`timescale 1ns / 1ps

interface fdrt_in_if #(
  parameter int DUTY_BITS = fdrt_pkg::DUTY_BITS_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic [fdrt_pkg::OP_W-1:0] op;
  logic [DUTY_BITS-1:0]      duty_request;

  modport source (output valid, op, duty_request, input ready);
  modport sink   (input valid, op, duty_request, output ready);
endinterface

// ===== hw/rtl/fdrt_out_if.sv =====
`timescale 1ns / 1ps

interface fdrt_out_if #(
  parameter int DUTY_BITS = fdrt_pkg::DUTY_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic [DUTY_BITS-1:0]       pwm_duty;
  logic [DUTY_BITS-1:0]       requested_duty;
  logic [fdrt_pkg::OUT_W-1:0] runtime_ms;
  logic [fdrt_pkg::OUT_W-1:0] rpm;
  logic                       rpm_valid;

  modport source (output valid, pwm_duty, requested_duty, runtime_ms, rpm, rpm_valid,
                  input ready);
  modport sink   (input valid, pwm_duty, requested_duty, runtime_ms, rpm, rpm_valid,
                  output ready);
endinterface

// ===== hw/rtl/fdrt_cfg_if.sv =====
`timescale 1ns / 1ps

interface fdrt_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [fdrt_pkg::CFG_IDX_W-1:0]  index;
  logic [fdrt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fdrt_ctrl.sv =====
`timescale 1ns / 1ps

module fdrt_ctrl #(
  parameter int NUM_BITS = fdrt_pkg::COUNT_BITS_DEF + fdrt_pkg::NUM_EXTRA
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  fdrt_pkg::sts_t sts,
  output fdrt_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(NUM_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BITS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one item: accept, optional multiply and divide, then push the result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.need_div ? S_MUL : S_PUSH;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_PUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/fdrt_datapath.sv =====
`timescale 1ns / 1ps

module fdrt_datapath #(
  parameter int DUTY_BITS  = fdrt_pkg::DUTY_BITS_DEF,
  parameter int COUNT_BITS = fdrt_pkg::COUNT_BITS_DEF,
  parameter int NUM_BITS   = fdrt_pkg::COUNT_BITS_DEF + fdrt_pkg::NUM_EXTRA
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fdrt_pkg::cmd_t                  cmd,
  output fdrt_pkg::sts_t                  sts,
  input  logic                            cfg_valid,
  input  logic [fdrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdrt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [fdrt_pkg::OP_W-1:0]       in_op,
  input  logic [DUTY_BITS-1:0]            in_duty_request,
  output logic [DUTY_BITS-1:0]            pwm_duty,
  output logic [DUTY_BITS-1:0]            requested_duty,
  output logic [fdrt_pkg::OUT_W-1:0]      runtime_ms,
  output logic [fdrt_pkg::OUT_W-1:0]      rpm,
  output logic                            rpm_valid
);

  localparam int OUT_W = fdrt_pkg::OUT_W;
  localparam int CMP_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
  localparam int DIV_W = COUNT_BITS + 1;
  localparam int REM_W = COUNT_BITS + 2;
  localparam logic [NUM_BITS-1:0] K_RPM = NUM_BITS'(fdrt_pkg::RPM_NUM);

  // Configuration registers
  logic [DUTY_BITS-1:0] min_duty_r;
  logic [DUTY_BITS-1:0] off_thresh_r;
  logic                 allow_off_r;
  logic [OUT_W-1:0]     min_runtime_r;

  // Block state
  logic [DUTY_BITS-1:0]  applied_r, applied_nxt;
  logic [DUTY_BITS-1:0]  last_req_r, last_req_nxt;
  logic [COUNT_BITS-1:0] since_r, since_nxt;
  logic [COUNT_BITS-1:0] edges_r, edges_nxt;
  logic [COUNT_BITS-1:0] win_r, win_nxt;
  logic                  win_open_r, win_open_nxt;
  logic                  rpm_ok_r, rpm_ok_nxt;

  // Divider
  logic [COUNT_BITS-1:0] edge_cap_r;
  logic [DIV_W-1:0]      div_r;
  logic [NUM_BITS-1:0]   num_r;
  logic [REM_W-1:0]      rem_r;
  logic [NUM_BITS-1:0]   quo_r;
  logic [REM_W-1:0]      rem_shift;
  logic                  rem_ge;

  // Output registers
  logic [DUTY_BITS-1:0] pwm_duty_r;
  logic [DUTY_BITS-1:0] req_duty_r;
  logic [OUT_W-1:0]     runtime_r;
  logic [OUT_W-1:0]     rpm_r;
  logic                 rpm_valid_r;

  logic [DUTY_BITS-1:0] shaped;
  logic [CMP_W-1:0]     since_ext;
  logic [CMP_W-1:0]     min_rt_ext;
  logic [OUT_W-1:0]     runtime_sat;
  logic [OUT_W-1:0]     quo_sat;

  assign since_ext  = CMP_W'(since_r);
  assign min_rt_ext = CMP_W'(min_runtime_r);

  assign sts.need_div = (in_op == fdrt_pkg::OP_READ) && win_open_r && (win_r != '0);

  // Shape the duty request
  always_comb begin
    if (in_duty_request <= off_thresh_r) begin
      shaped = '0;
    end else if (in_duty_request < min_duty_r) begin
      shaped = min_duty_r;
    end else begin
      shaped = in_duty_request;
    end
    if (shaped == '0 && !allow_off_r) begin
      shaped = min_duty_r;
    end
    if (min_runtime_r != '0 && shaped == '0 && since_ext < min_rt_ext) begin
      shaped = min_duty_r;
    end
  end

  // Apply one item to the state
  always_comb begin
    applied_nxt  = applied_r;
    last_req_nxt = last_req_r;
    since_nxt    = since_r;
    edges_nxt    = edges_r;
    win_nxt      = win_r;
    win_open_nxt = win_open_r;
    rpm_ok_nxt   = rpm_ok_r;
    if (cmd.accept) begin
      rpm_ok_nxt = 1'b0;
      case (in_op)
        fdrt_pkg::OP_DUTY: begin
          last_req_nxt = in_duty_request;
          applied_nxt  = shaped;
          if (applied_r == '0 && shaped != '0) begin
            since_nxt = '0;
          end
        end
        fdrt_pkg::OP_TICK: begin
          since_nxt = (&since_r) ? since_r : since_r + 1'b1;
          if (win_open_r) begin
            win_nxt = (&win_r) ? win_r : win_r + 1'b1;
          end
        end
        fdrt_pkg::OP_EDGE: begin
          edges_nxt = (&edges_r) ? edges_r : edges_r + 1'b1;
        end
        default: begin
          rpm_ok_nxt   = sts.need_div;
          edges_nxt    = '0;
          win_nxt      = '0;
          win_open_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_duty_r    <= '0;
      off_thresh_r  <= '0;
      allow_off_r   <= 1'b1;
      min_runtime_r <= fdrt_pkg::MIN_RUNTIME_RST;
      applied_r     <= '0;
      last_req_r    <= '0;
      since_r       <= '0;
      edges_r       <= '0;
      win_r         <= '0;
      win_open_r    <= 1'b0;
      rpm_ok_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          fdrt_pkg::REG_MIN_DUTY:    min_duty_r    <= cfg_data[DUTY_BITS-1:0];
          fdrt_pkg::REG_OFF_THRESH:  off_thresh_r  <= cfg_data[DUTY_BITS-1:0];
          fdrt_pkg::REG_ALLOW_OFF:   allow_off_r   <= cfg_data[0];
          fdrt_pkg::REG_MIN_RUNTIME: min_runtime_r <= cfg_data[OUT_W-1:0];
          default: begin
          end
        endcase
      end
      applied_r  <= applied_nxt;
      last_req_r <= last_req_nxt;
      since_r    <= since_nxt;
      edges_r    <= edges_nxt;
      win_r      <= win_nxt;
      win_open_r <= win_open_nxt;
      rpm_ok_r   <= rpm_ok_nxt;
    end
  end

  // Restoring division, one quotient bit per step
  assign rem_shift = {rem_r[REM_W-2:0], num_r[NUM_BITS-1]};
  assign rem_ge    = (rem_shift >= REM_W'(div_r));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      edge_cap_r <= edges_r;
      div_r      <= {win_r, 1'b0};
    end
    if (cmd.mul) begin
      num_r <= NUM_BITS'(edge_cap_r) * K_RPM + NUM_BITS'(div_r[DIV_W-1:1]);
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_BITS-2:0], 1'b0};
      rem_r <= rem_ge ? rem_shift - REM_W'(div_r) : rem_shift;
      quo_r <= {quo_r[NUM_BITS-2:0], rem_ge};
    end
  end

  // Saturate to the 32-bit result fields
  assign quo_sat = (|quo_r[NUM_BITS-1:OUT_W]) ? '1 : quo_r[OUT_W-1:0];

  generate
    if (COUNT_BITS > OUT_W) begin : g_rt_wide
      assign runtime_sat = (|since_r[COUNT_BITS-1:OUT_W]) ? '1 : since_r[OUT_W-1:0];
    end else begin : g_rt_narrow
      assign runtime_sat = OUT_W'(since_r);
    end
  endgenerate

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pwm_duty_r  <= applied_r;
      req_duty_r  <= last_req_r;
      runtime_r   <= runtime_sat;
      rpm_r       <= rpm_ok_r ? quo_sat : '0;
      rpm_valid_r <= rpm_ok_r;
    end
  end

  assign pwm_duty       = pwm_duty_r;
  assign requested_duty = req_duty_r;
  assign runtime_ms     = runtime_r;
  assign rpm            = rpm_r;
  assign rpm_valid      = rpm_valid_r;

endmodule

// ===== hw/rtl/fan_duty_runtime_tach_control.sv =====
`timescale 1ns / 1ps
// Fan duty shaping with minimum runtime and tachometer speed measurement.
// in_ch carries one item per transaction: op selects a duty request, a 1 ms
// tick, a tach falling edge or an rpm read; duty_request is used for the first.
// out_ch returns exactly one result per item: applied duty, last request,
// runtime since the last start, and rpm with its valid flag on reads.
// cfg_ch writes min_duty, off_threshold, allow_off and min_runtime_ms by index;
// it is ready whenever reset is released and takes effect on the next item.
// Items are handled one at a time. A duty request, tick, edge, or a read over
// an empty window passes from acceptance to the push state, which loads its
// result once the output register is free; in_ch is ready again at the same
// time. A read over a nonempty window runs a multiply and a restoring divider
// that retires one quotient bit per cycle, COUNT_BITS + 17 bits, before the
// push. A result waits in the output register while the receiver stalls; the
// next item is taken meanwhile, and its result waits until the register is
// free.
// Synchronous reset clears duty, counters and the rpm window and restores the
// register defaults; both in_ch and cfg_ch hold ready low during reset.

module fan_duty_runtime_tach_control #(
  parameter int DUTY_BITS  = fdrt_pkg::DUTY_BITS_DEF,
  parameter int COUNT_BITS = fdrt_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fdrt_in_if.sink     in_ch,
  fdrt_out_if.source  out_ch,
  fdrt_cfg_if.sink    cfg_ch
);

  localparam int NUM_BITS = COUNT_BITS + fdrt_pkg::NUM_EXTRA;

  fdrt_pkg::cmd_t cmd;
  fdrt_pkg::sts_t sts;

  // Configuration writes land at once outside reset
  assign cfg_ch.ready = rst_n;

  fdrt_ctrl #(
    .NUM_BITS (NUM_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fdrt_datapath #(
    .DUTY_BITS  (DUTY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .NUM_BITS   (NUM_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .in_op           (in_ch.op),
    .in_duty_request (in_ch.duty_request),
    .pwm_duty        (out_ch.pwm_duty),
    .requested_duty  (out_ch.requested_duty),
    .runtime_ms      (out_ch.runtime_ms),
    .rpm             (out_ch.rpm),
    .rpm_valid       (out_ch.rpm_valid)
  );

endmodule

// ===== hw/rtl/fdrt_checker.sv =====
`timescale 1ns / 1ps

module fdrt_checker #(
  parameter int DUTY_BITS = fdrt_pkg::DUTY_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [DUTY_BITS-1:0]       pwm_duty,
  input logic [DUTY_BITS-1:0]       requested_duty,
  input logic [fdrt_pkg::OUT_W-1:0] runtime_ms,
  input logic [fdrt_pkg::OUT_W-1:0] rpm,
  input logic                       rpm_valid
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pwm_duty) && $stable(requested_duty)
      && $stable(runtime_ms) && $stable(rpm) && $stable(rpm_valid))
    else $error("stalled result changed");

  // Drop ready after each accepted transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // A result without a fresh measurement carries zero rpm
  a_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !rpm_valid |-> rpm == '0)
    else $error("rpm nonzero without valid flag");

endmodule

bind fan_duty_runtime_tach_control fdrt_checker #(
  .DUTY_BITS (DUTY_BITS)
) u_fdrt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .pwm_duty       (out_ch.pwm_duty),
  .requested_duty (out_ch.requested_duty),
  .runtime_ms     (out_ch.runtime_ms),
  .rpm            (out_ch.rpm),
  .rpm_valid      (out_ch.rpm_valid)
);

// ===== tb/fan_duty_runtime_tach_control_tb.sv =====
`timescale 1ns / 1ps

module fan_duty_runtime_tach_control_tb;

  localparam int DW    = fdrt_pkg::DUTY_BITS_DEF;
  localparam int CW    = fdrt_pkg::COUNT_BITS_DEF;
  localparam int OUT_W = fdrt_pkg::OUT_W;
  localparam int OP_W  = fdrt_pkg::OP_W;

  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_LIMIT       = 20000;
  localparam int END_CYCLES        = 64;
  localparam int MAX_GAP           = 20;
  // edges packed into a one-tick window for a high speed reading
  localparam int FAST_EDGES        = 60;
  localparam longint TIMEOUT_NS    = 40_000_000;

  typedef struct packed {
    logic [DW-1:0]    pwm_duty;
    logic [DW-1:0]    requested_duty;
    logic [OUT_W-1:0] runtime_ms;
    logic [OUT_W-1:0] rpm;
    logic             rpm_valid;
  } fan_status_t;

  logic clk;
  logic rst_n;

  fdrt_in_if  #(.DUTY_BITS(DW)) in_bus ();
  fdrt_out_if #(.DUTY_BITS(DW)) out_bus ();
  fdrt_cfg_if                   cfg_bus ();

  fan_duty_runtime_tach_control #(
    .DUTY_BITS  (DW),
    .COUNT_BITS (CW)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Shadow configuration
  logic [DW-1:0]    cfg_min_duty;
  logic [DW-1:0]    cfg_off_thresh;
  logic             cfg_allow_off;
  logic [OUT_W-1:0] cfg_min_runtime;

  // Shadow controller state
  logic [DW-1:0] duty_now;
  logic [DW-1:0] duty_last_req;
  logic [CW-1:0] run_ms;
  logic [CW-1:0] tach_edges;
  logic [CW-1:0] tach_window_ms;
  logic          tach_window_open;

  fan_status_t expected_status_q[$];

  int fail_count       = 0;
  int items_sent       = 0;
  int tx_idle_pct      = 0;
  int rx_idle_pct      = 0;
  int stalls_requested = 0;
  int stalls_served    = 0;
  int stall_left       = 0;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CW-1:0] count_up(input logic [CW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void reset_shadow();
    cfg_min_duty     = '0;
    cfg_off_thresh   = '0;
    cfg_allow_off    = 1'b1;
    cfg_min_runtime  = fdrt_pkg::MIN_RUNTIME_RST;
    duty_now         = '0;
    duty_last_req    = '0;
    run_ms           = '0;
    tach_edges       = '0;
    tach_window_ms   = '0;
    tach_window_open = 1'b0;
  endfunction

  // Advance the shadow state by one transaction and return its status
  function automatic fan_status_t predict_fan_status(input logic [OP_W-1:0] op,
                                                     input logic [DW-1:0]   req);
    fan_status_t s;
    logic [DW-1:0] d;
    logic [63:0]   num;
    logic [63:0]   quo;
    s.rpm       = '0;
    s.rpm_valid = 1'b0;
    case (op)
      fdrt_pkg::OP_DUTY: begin
        d             = req;
        duty_last_req = req;
        if (d <= cfg_off_thresh) d = '0;
        else if (d < cfg_min_duty) d = cfg_min_duty;
        if (d == '0 && !cfg_allow_off) d = cfg_min_duty;
        // hold the fan on until the minimum runtime has elapsed
        if (cfg_min_runtime != '0 && d == '0 && 64'(run_ms) < 64'(cfg_min_runtime))
          d = cfg_min_duty;
        if (duty_now == '0 && d != '0) run_ms = '0;
        duty_now = d;
      end
      fdrt_pkg::OP_TICK: begin
        run_ms = count_up(run_ms);
        if (tach_window_open) tach_window_ms = count_up(tach_window_ms);
      end
      fdrt_pkg::OP_EDGE: begin
        tach_edges = count_up(tach_edges);
      end
      default: begin
        // round half up: (2*edges*30000 + w) / (2*w)
        if (tach_window_open && tach_window_ms != '0) begin
          num = 64'(tach_edges) * 64'(fdrt_pkg::RPM_NUM) + 64'(tach_window_ms);
          quo = num / (64'(tach_window_ms) << 1);
          s.rpm       = (quo > 64'hFFFF_FFFF) ? '1 : quo[OUT_W-1:0];
          s.rpm_valid = 1'b1;
        end
        tach_edges       = '0;
        tach_window_ms   = '0;
        tach_window_open = 1'b1;
      end
    endcase
    s.pwm_duty       = duty_now;
    s.requested_duty = duty_last_req;
    s.runtime_ms     = OUT_W'(run_ms);
    return s;
  endfunction

  // Receiver: random stalls plus an occasional long hold-off
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (stalls_served != stalls_requested) begin
        stalls_served++;
        stall_left = LONG_STALL_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expected status
  always @(posedge clk) begin : check_results
    fan_status_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_status_q.size() == 0) begin
        $error("unexpected result: pwm_duty %0d rpm %0d", out_bus.pwm_duty, out_bus.rpm);
        fail_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (out_bus.pwm_duty !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, out_bus.pwm_duty);
          fail_count++;
        end
        if (out_bus.requested_duty !== want.requested_duty) begin
          $error("requested_duty: expected %0d, actual %0d",
                 want.requested_duty, out_bus.requested_duty);
          fail_count++;
        end
        if (out_bus.runtime_ms !== want.runtime_ms) begin
          $error("runtime_ms: expected %0d, actual %0d", want.runtime_ms, out_bus.runtime_ms);
          fail_count++;
        end
        if (out_bus.rpm !== want.rpm) begin
          $error("rpm: expected %0d, actual %0d", want.rpm, out_bus.rpm);
          fail_count++;
        end
        if (out_bus.rpm_valid !== want.rpm_valid) begin
          $error("rpm_valid: expected %0d, actual %0d", want.rpm_valid, out_bus.rpm_valid);
          fail_count++;
        end
      end
    end
  end

  // Offer one transaction after a random gap; valid is left high on return
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DW-1:0] duty);
    int gap;
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.op           <= op;
    in_bus.duty_request <= duty;
    do @(posedge clk); while (!in_bus.ready);
    expected_status_q.push_back(predict_fan_status(op, duty));
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    int waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_status_q.size() != 0) begin
      $error("results missing: %0d still expected", expected_status_q.size());
      fail_count++;
      expected_status_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fdrt_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [fdrt_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      fdrt_pkg::REG_MIN_DUTY:    cfg_min_duty    = data[DW-1:0];
      fdrt_pkg::REG_OFF_THRESH:  cfg_off_thresh  = data[DW-1:0];
      fdrt_pkg::REG_ALLOW_OFF:   cfg_allow_off   = data[0];
      fdrt_pkg::REG_MIN_RUNTIME: cfg_min_runtime = data;
      default: begin
      end
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write all registers, with junk above each narrow field
  task automatic apply_settings(input int unsigned md, input int unsigned ot,
                                input int unsigned ao, input logic [31:0] mr);
    write_reg(fdrt_pkg::REG_MIN_DUTY, ($urandom() & ~32'hFF) | (md & 32'hFF));
    write_reg(fdrt_pkg::REG_OFF_THRESH, ($urandom() & ~32'hFF) | (ot & 32'hFF));
    write_reg(fdrt_pkg::REG_ALLOW_OFF, ($urandom() & ~32'h1) | (ao & 32'h1));
    write_reg(fdrt_pkg::REG_MIN_RUNTIME, mr);
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return fdrt_pkg::OP_DUTY;
    if (r < 65) return fdrt_pkg::OP_TICK;
    if (r < 90) return fdrt_pkg::OP_EDGE;
    return fdrt_pkg::OP_READ;
  endfunction

  // Favour values around the threshold and the minimum duty
  function automatic logic [DW-1:0] pick_duty();
    case ($urandom_range(5))
      0:       return DW'(cfg_off_thresh + DW'($urandom_range(2)) - 1'b1);
      1:       return DW'(cfg_min_duty + DW'($urandom_range(2)) - 1'b1);
      2:       return '0;
      3:       return '1;
      default: return DW'($urandom());
    endcase
  endfunction

  // First read, empty window, window with no edges, rounded speed
  task automatic test_rpm_windows();
    send_item(fdrt_pkg::OP_READ, 8'h5A);
    send_item(fdrt_pkg::OP_READ, 8'hA5);
    send_item(fdrt_pkg::OP_TICK, 8'h00);
    send_item(fdrt_pkg::OP_READ, 8'hFF);
    send_item(fdrt_pkg::OP_EDGE, 8'h33);
    repeat (7) send_item(fdrt_pkg::OP_TICK, 8'hCC);
    send_item(fdrt_pkg::OP_READ, 8'h00);
    settle();
  endtask

  // Threshold, minimum duty, allow_off and the field extremes
  task automatic test_duty_shaping();
    apply_settings(40, 20, 1, 0);
    send_item(fdrt_pkg::OP_DUTY, 8'd0);
    send_item(fdrt_pkg::OP_DUTY, 8'd20);
    send_item(fdrt_pkg::OP_DUTY, 8'd21);
    send_item(fdrt_pkg::OP_DUTY, 8'd255);
    send_item(fdrt_pkg::OP_DUTY, 8'd0);
    settle();
    write_reg(fdrt_pkg::REG_ALLOW_OFF, 32'd0);
    send_item(fdrt_pkg::OP_DUTY, 8'd5);
    settle();
    apply_settings(255, 0, 1, 0);
    send_item(fdrt_pkg::OP_DUTY, 8'd1);
    settle();
    apply_settings(255, 255, 0, 0);
    send_item(fdrt_pkg::OP_DUTY, 8'd255);
    settle();
  endtask

  // Off is held back until the runtime since the last start has elapsed
  task automatic test_min_runtime();
    apply_settings(10, 0, 1, 3);
    send_item(fdrt_pkg::OP_DUTY, 8'd0);
    send_item(fdrt_pkg::OP_DUTY, 8'd50);
    send_item(fdrt_pkg::OP_DUTY, 8'd0);
    send_item(fdrt_pkg::OP_TICK, 8'd0);
    send_item(fdrt_pkg::OP_TICK, 8'd0);
    send_item(fdrt_pkg::OP_DUTY, 8'd0);
    send_item(fdrt_pkg::OP_TICK, 8'd0);
    send_item(fdrt_pkg::OP_DUTY, 8'd0);
    settle();
  endtask

  // Many edges in a one-tick window give a high speed reading
  task automatic test_rpm_high_speed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_item(fdrt_pkg::OP_READ, 8'd0);
    send_item(fdrt_pkg::OP_TICK, 8'd0);
    repeat (FAST_EDGES) send_item(fdrt_pkg::OP_EDGE, DW'($urandom()));
    send_item(fdrt_pkg::OP_READ, 8'd0);
    settle();
  endtask

  task automatic pick_settings(input int kind);
    case (kind % 4)
      0: apply_settings($urandom_range(255), $urandom_range(255), $urandom_range(1),
                        $urandom_range(40));
      1: apply_settings(0, 0, 0, 0);
      2: apply_settings(255, 255, 1, 32'hFFFF_FFFF);
      default: apply_settings($urandom_range(1, 80), $urandom_range(60), 1,
                              $urandom_range(1, 20));
    endcase
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input int n_items, input int n_settings);
    int target;
    int n_ticks;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int s = 0; s < n_settings; s++) begin
      settle();
      pick_settings(s + $urandom_range(3));
      target = items_sent + n_items / n_settings;
      while (items_sent < target) begin
        case ($urandom_range(9))
          4, 5, 6: begin
            // measurement window: read, ticks with edges between, read
            send_item(fdrt_pkg::OP_READ, DW'($urandom()));
            n_ticks = $urandom_range(1, 12);
            repeat (n_ticks) begin
              repeat ($urandom_range(6)) send_item(fdrt_pkg::OP_EDGE, DW'($urandom()));
              send_item(fdrt_pkg::OP_TICK, DW'($urandom()));
            end
            send_item(fdrt_pkg::OP_READ, DW'($urandom()));
          end
          7, 8: begin
            // start the fan, let time pass, then ask for off
            send_item(fdrt_pkg::OP_DUTY, DW'($urandom_range(1, 255)));
            repeat ($urandom_range(30)) send_item(fdrt_pkg::OP_TICK, DW'($urandom()));
            send_item(fdrt_pkg::OP_DUTY, DW'($urandom_range(cfg_off_thresh)));
          end
          9: begin
            send_item(OP_W'($urandom_range(3)), DW'($urandom()));
          end
          default: begin
            send_item(pick_op(), pick_duty());
          end
        endcase
      end
    end
    settle();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stalls_requested++;
    repeat (40) send_item(pick_op(), pick_duty());
    settle();
  endtask

  initial begin
    reset_shadow();
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.op           = fdrt_pkg::OP_TICK;
    in_bus.duty_request = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = fdrt_pkg::REG_MIN_DUTY;
    cfg_bus.data        = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rpm_windows();
    test_duty_shaping();
    test_min_runtime();
    test_random_traffic(33, 82, 380, 4);
    test_random_traffic(82, 33, 380, 4);
    test_random_traffic(0, 0, 380, 4);
    test_output_backpressure();
    test_rpm_high_speed();

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
